>>> hw/rtl/chip8_instruction_core_assert.svh
`ifndef CHIP8_INSTRUCTION_CORE_ASSERT_SVH
`define CHIP8_INSTRUCTION_CORE_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define C8IC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c8ic check failed");

// next-cycle implication
`define C8IC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c8ic check failed");

`endif

>>> hw/rtl/c8ic_pkg.sv
package c8ic_pkg;

    // memory geometry
    localparam int MEM_AW     = 12;
    localparam int MEM_BYTES  = 4096;
    localparam int FONT_BYTES = 80;
    localparam int NUM_REGS   = 16;
    localparam int ROWS       = 32;
    localparam int COLS       = 64;
    localparam logic [MEM_AW-1:0] PC_START = 12'h200;
    localparam logic [MEM_AW-1:0] MEM_LAST = 12'hFFF;

    // input and output word sizes
    localparam int IN_W  = 72;
    localparam int OUT_W = 112;

    // hex font glyphs
    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // item kinds on tuser
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_EXEC = 2'd1,
        OP_ROW  = 2'd2
    } op_kind_t;

    // instruction groups by top nibble
    typedef enum logic [3:0] {
        I_SYS  = 4'h0, I_JP   = 4'h1, I_CALL = 4'h2, I_SE   = 4'h3,
        I_SNE  = 4'h4, I_SER  = 4'h5, I_LD   = 4'h6, I_ADD  = 4'h7,
        I_ALU  = 4'h8, I_SNER = 4'h9, I_LDI  = 4'hA, I_JPV  = 4'hB,
        I_RND  = 4'hC, I_DRW  = 4'hD, I_KEY  = 4'hE, I_MISC = 4'hF
    } instr_grp_t;

    localparam logic [15:0] SYS_CLS = 16'h00E0;
    localparam logic [15:0] SYS_RET = 16'h00EE;
    localparam logic [7:0]  K_SKP   = 8'h9E;
    localparam logic [7:0]  K_SKNP  = 8'hA1;
    localparam logic [7:0]  F_GET_DT = 8'h07;
    localparam logic [7:0]  F_WAITK  = 8'h0A;
    localparam logic [7:0]  F_SET_DT = 8'h15;
    localparam logic [7:0]  F_SET_ST = 8'h18;
    localparam logic [7:0]  F_ADD_I  = 8'h1E;
    localparam logic [7:0]  F_FONT   = 8'h29;
    localparam logic [7:0]  F_BCD    = 8'h33;
    localparam logic [7:0]  F_STORE  = 8'h55;
    localparam logic [7:0]  F_LOAD   = 8'h65;
    localparam logic [3:0]  FLAG_REG = 4'hF;

    // alu functions, codes follow the low nibble of 8XYn
    typedef enum logic [3:0] {
        ALU_MOV  = 4'h0, ALU_OR  = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3,
        ALU_ADD  = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7,
        ALU_SHL  = 4'hE
    } alu_fn_t;

    typedef struct packed {
        logic [7:0] res;
        logic       flag;
        logic       eq;
    } alu_out_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_ROW, ST_FETCH_HI, ST_FETCH_LO, ST_READ_X,
        ST_READ_Y, ST_EXEC, ST_FLAG, ST_RET, ST_DRAW_RD, ST_DRAW_WR,
        ST_CLS, ST_BCD, ST_STORE_RD, ST_STORE_WR, ST_LOAD_RD, ST_LOAD_WR,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/c8ic_ram.sv
module c8ic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/c8ic_alu.sv
module c8ic_alu
    import c8ic_pkg::*;
(
    input  logic [7:0] a,
    input  logic [7:0] b,
    input  alu_fn_t    fn,
    output alu_out_t   y
);

    logic [8:0] sum;
    logic [8:0] dif;
    logic [8:0] difn;

    assign sum  = {1'b0, a} + {1'b0, b};
    assign dif  = {1'b0, a} - {1'b0, b};
    assign difn = {1'b0, b} - {1'b0, a};

    // byte operation and its flag
    always_comb
    begin
        y.eq   = (a == b);
        y.res  = a;
        y.flag = 1'b0;
        unique case (fn)
            ALU_MOV:  y.res = b;
            ALU_OR:   y.res = a | b;
            ALU_AND:  y.res = a & b;
            ALU_XOR:  y.res = a ^ b;
            ALU_ADD:
            begin
                y.res  = sum[7:0];
                y.flag = sum[8];
            end
            ALU_SUB:
            begin
                y.res  = dif[7:0];
                y.flag = ~dif[8];
            end
            ALU_SHR:
            begin
                y.res  = {1'b0, a[7:1]};
                y.flag = a[0];
            end
            ALU_SUBN:
            begin
                y.res  = difn[7:0];
                y.flag = ~difn[8];
            end
            ALU_SHL:
            begin
                y.res  = {a[6:0], 1'b0};
                y.flag = a[7];
            end
            default: y.res = a;
        endcase
    end

endmodule

>>> hw/rtl/chip8_instruction_core.sv
// CHIP-8 core with 4096-byte memory, sixteen byte registers, a return
// stack and a 64x32 one-bit display.
// Input channel s_*: one word is one operation, chosen by s_tuser:
// load a memory byte, execute one instruction, or read a display row.
// Output channel m_*: exactly one result word per input word, holding
// PC, I, the timer registers, the display row and three status flags.
// Plain instructions fetch two bytes, read VX and VY, then execute and
// write VF if they set it; a return reads the stack, a sprite draw reads
// and writes each row, FX55/FX65 move each register, BCD writes three
// digits, clear screen zeroes each row. One word is taken at a time;
// each step is set by the memory's single read port and the register
// file's single read port. After reset a clearing pass loads the font,
// zeroes memory, registers, stack and display; s_tready stays low until
// it ends. A finished result waits in the output register while m_tready
// is low, and the next word is still accepted; it is then held at its
// last step until the output register is free.
module chip8_instruction_core
    import c8ic_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // load_address, load_data, row_select, keys_held, keys_released,
    // random_byte, zero fill
    input  logic [IN_W-1:0]  s_tdata,
    // opcode
    input  logic [1:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // program_counter, index_value, delay_value, sound_value, display_row,
    // waiting_key, stack_error, unknown_instruction, zero fill
    output logic [OUT_W-1:0] m_tdata
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    // registers
    state_t            state_reg, state_next;
    logic [MEM_AW-1:0] pc_reg, pc_next;
    logic [MEM_AW-1:0] idx_reg, idx_next;
    logic [7:0]        delay_reg, delay_next;
    logic [7:0]        sound_reg, sound_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic [15:0]       op_reg, op_next;
    logic [7:0]        vx_reg, vx_next;
    logic [7:0]        vy_reg, vy_next;
    logic [MEM_AW-1:0] cnt_reg, cnt_next;
    logic              hit_reg, hit_next;
    logic              flag_reg, flag_next;
    logic [15:0]       held_reg, held_next;
    logic [15:0]       rel_reg, rel_next;
    logic [7:0]        rnd_reg, rnd_next;
    logic              wait_reg, wait_next;
    logic              serr_reg, serr_next;
    logic              unk_reg, unk_next;
    logic [COLS-1:0]   row_reg, row_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  out_reg, out_next;

    // memory ports
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata, mem_rdata;
    logic              reg_we;
    logic [3:0]        reg_waddr, reg_raddr;
    logic [7:0]        reg_wdata, reg_rdata;
    logic              stk_we;
    logic [SAW-1:0]    stk_waddr, stk_raddr;
    logic [MEM_AW-1:0] stk_wdata, stk_rdata;
    logic              frm_we;
    logic [4:0]        frm_waddr, frm_raddr;
    logic [COLS-1:0]   frm_wdata, frm_rdata;

    // decode helpers
    logic [3:0]        op_x, op_y, op_n;
    logic [7:0]        op_nn;
    logic [11:0]       op_nnn;
    instr_grp_t        op_grp;
    logic [7:0]        vy_in;
    alu_fn_t           alu_fn;
    logic [7:0]        alu_b;
    alu_out_t          alu_y;
    logic [MEM_AW-1:0] mem_idx;
    logic [5:0]        draw_y;
    logic              draw_end;
    logic [7:0]        sprite_rev;
    logic [COLS-1:0]   draw_mask;
    logic [1:0]        bcd_hund;
    logic [7:0]        bcd_rem;
    logic [14:0]       tens_prod;
    logic [3:0]        bcd_tens;
    logic [7:0]        bcd_ones;
    logic [7:0]        bcd_digit;
    logic [3:0]        key_idx;
    logic              key_found;
    logic              key_down;
    logic [MEM_AW:0]   idx_sum;
    logic              in_fire;

    assign op_x   = op_reg[11:8];
    assign op_y   = op_reg[7:4];
    assign op_n   = op_reg[3:0];
    assign op_nn  = op_reg[7:0];
    assign op_nnn = op_reg[11:0];
    assign op_grp = instr_grp_t'(op_reg[15:12]);
    assign vy_in  = reg_rdata;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // shared byte unit
    assign alu_fn = (op_grp == I_ALU) ? alu_fn_t'(op_n) : ALU_ADD;
    assign alu_b  = (op_grp == I_SE || op_grp == I_SNE || op_grp == I_ADD) ? op_nn : vy_in;

    c8ic_alu u_alu (
        .a  (vx_reg),
        .b  (alu_b),
        .fn (alu_fn),
        .y  (alu_y)
    );

    // sprite row geometry, start wraps and the rest clips
    assign mem_idx    = idx_reg + cnt_reg;
    assign draw_y     = {1'b0, vy_reg[4:0]} + cnt_reg[5:0];
    assign draw_end   = (cnt_reg >= {8'd0, op_n}) || draw_y[5];
    assign sprite_rev = {mem_rdata[0], mem_rdata[1], mem_rdata[2], mem_rdata[3],
                         mem_rdata[4], mem_rdata[5], mem_rdata[6], mem_rdata[7]};
    assign draw_mask  = {{(COLS-8){1'b0}}, sprite_rev} << vx_reg[5:0];

    // decimal digits of VX, tens by reciprocal multiply
    assign bcd_hund  = (vx_reg >= 8'd200) ? 2'd2 : ((vx_reg >= 8'd100) ? 2'd1 : 2'd0);
    assign bcd_rem   = vx_reg - ((bcd_hund == 2'd2) ? 8'd200 :
                                 ((bcd_hund == 2'd1) ? 8'd100 : 8'd0));
    assign tens_prod = {8'd0, bcd_rem[6:0]} * 15'd205;
    assign bcd_tens  = tens_prod[14:11];
    assign bcd_ones  = bcd_rem - {1'b0, bcd_tens, 3'b0} - {3'b0, bcd_tens, 1'b0};

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    bcd_digit = {6'd0, bcd_hund};
            2'd1:    bcd_digit = {4'd0, bcd_tens};
            default: bcd_digit = bcd_ones;
        endcase
    end

    // lowest released key
    always_comb
    begin
        key_idx   = 4'd0;
        key_found = 1'b0;
        for (int i = 15; i >= 0; i--)
        begin
            if (rel_reg[i])
            begin
                key_idx   = 4'(i);
                key_found = 1'b1;
            end
        end
    end

    assign key_down = held_reg[vx_reg[3:0]];
    assign idx_sum  = {1'b0, idx_reg} + {5'd0, vx_reg};

    c8ic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk (clk), .we (mem_we), .waddr (mem_waddr), .wdata (mem_wdata),
        .raddr (mem_raddr), .rdata (mem_rdata)
    );

    c8ic_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_regs (
        .clk (clk), .we (reg_we), .waddr (reg_waddr), .wdata (reg_wdata),
        .raddr (reg_raddr), .rdata (reg_rdata)
    );

    c8ic_ram #(.WIDTH(MEM_AW), .DEPTH(STACK_DEPTH)) u_stack (
        .clk (clk), .we (stk_we), .waddr (stk_waddr), .wdata (stk_wdata),
        .raddr (stk_raddr), .rdata (stk_rdata)
    );

    c8ic_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_frame (
        .clk (clk), .we (frm_we), .waddr (frm_waddr), .wdata (frm_wdata),
        .raddr (frm_raddr), .rdata (frm_rdata)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            pc_reg       <= PC_START;
            idx_reg      <= '0;
            delay_reg    <= '0;
            sound_reg    <= '0;
            sp_reg       <= '0;
            op_reg       <= '0;
            vx_reg       <= '0;
            vy_reg       <= '0;
            cnt_reg      <= '0;
            hit_reg      <= 1'b0;
            flag_reg     <= 1'b0;
            held_reg     <= '0;
            rel_reg      <= '0;
            rnd_reg      <= '0;
            wait_reg     <= 1'b0;
            serr_reg     <= 1'b0;
            unk_reg      <= 1'b0;
            row_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            out_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            idx_reg      <= idx_next;
            delay_reg    <= delay_next;
            sound_reg    <= sound_next;
            sp_reg       <= sp_next;
            op_reg       <= op_next;
            vx_reg       <= vx_next;
            vy_reg       <= vy_next;
            cnt_reg      <= cnt_next;
            hit_reg      <= hit_next;
            flag_reg     <= flag_next;
            held_reg     <= held_next;
            rel_reg      <= rel_next;
            rnd_reg      <= rnd_next;
            wait_reg     <= wait_next;
            serr_reg     <= serr_next;
            unk_reg      <= unk_next;
            row_reg      <= row_next;
            m_tvalid_reg <= m_tvalid_next;
            out_reg      <= out_next;
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        idx_next      = idx_reg;
        delay_next    = delay_reg;
        sound_next    = sound_reg;
        sp_next       = sp_reg;
        op_next       = op_reg;
        vx_next       = vx_reg;
        vy_next       = vy_reg;
        cnt_next      = cnt_reg;
        hit_next      = hit_reg;
        flag_next     = flag_reg;
        held_next     = held_reg;
        rel_next      = rel_reg;
        rnd_next      = rnd_reg;
        wait_next     = wait_reg;
        serr_next     = serr_reg;
        unk_next      = unk_reg;
        row_next      = row_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        out_next      = out_reg;

        mem_we    = 1'b0;
        mem_waddr = mem_idx;
        mem_wdata = bcd_digit;
        mem_raddr = pc_reg;
        reg_we    = 1'b0;
        reg_waddr = op_x;
        reg_wdata = alu_y.res;
        reg_raddr = op_x;
        stk_we    = 1'b0;
        stk_waddr = sp_reg[SAW-1:0];
        stk_wdata = pc_reg;
        stk_raddr = sp_reg[SAW-1:0];
        frm_we    = 1'b0;
        frm_waddr = draw_y[4:0];
        frm_wdata = frm_rdata ^ draw_mask;
        frm_raddr = draw_y[4:0];

        unique case (state_reg)
            // power-up sweep over every store
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = (cnt_reg < MEM_AW'(FONT_BYTES)) ? FONT[cnt_reg[6:0]] : 8'd0;
                reg_we    = (cnt_reg < MEM_AW'(NUM_REGS));
                reg_waddr = cnt_reg[3:0];
                reg_wdata = 8'd0;
                stk_we    = (cnt_reg < MEM_AW'(STACK_DEPTH));
                stk_waddr = cnt_reg[SAW-1:0];
                stk_wdata = '0;
                frm_we    = (cnt_reg < MEM_AW'(ROWS));
                frm_waddr = cnt_reg[4:0];
                frm_wdata = '0;
                cnt_next  = cnt_reg + 12'd1;
                if (cnt_reg == MEM_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            // take a new word
            ST_IDLE:
            begin
                frm_raddr = s_tdata[24:20];
                if (in_fire)
                begin
                    held_next = s_tdata[40:25];
                    rel_next  = s_tdata[56:41];
                    rnd_next  = s_tdata[64:57];
                    wait_next = 1'b0;
                    serr_next = 1'b0;
                    unk_next  = 1'b0;
                    row_next  = '0;
                    unique case (op_kind_t'(s_tuser))
                        OP_LOAD:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = s_tdata[11:0];
                            mem_wdata  = s_tdata[19:12];
                            state_next = ST_DONE;
                        end
                        OP_EXEC: state_next = ST_FETCH_HI;
                        OP_ROW:  state_next = ST_ROW;
                        default: state_next = ST_DONE;
                    endcase
                end
            end

            ST_ROW:
            begin
                row_next   = frm_rdata;
                state_next = ST_DONE;
            end

            // instruction fetch, two bytes
            ST_FETCH_HI:
            begin
                mem_raddr  = pc_reg;
                state_next = ST_FETCH_LO;
            end

            ST_FETCH_LO:
            begin
                mem_raddr     = pc_reg + 12'd1;
                op_next[15:8] = mem_rdata;
                state_next    = ST_READ_X;
            end

            ST_READ_X:
            begin
                op_next[7:0] = mem_rdata;
                reg_raddr    = op_reg[11:8];
                state_next   = ST_READ_Y;
            end

            // second operand, V0 for the offset jump
            ST_READ_Y:
            begin
                vx_next    = reg_rdata;
                reg_raddr  = (op_grp == I_JPV) ? 4'd0 : op_y;
                pc_next    = pc_reg + 12'd2;
                state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                vy_next    = vy_in;
                state_next = ST_DONE;
                unique case (op_grp)
                    I_SYS:
                    begin
                        if (op_reg == SYS_CLS)
                        begin
                            cnt_next   = '0;
                            state_next = ST_CLS;
                        end
                        else if (op_reg == SYS_RET)
                        begin
                            if (sp_reg == '0 || sp_reg > SPW'(STACK_DEPTH))
                            begin
                                serr_next = 1'b1;
                                sp_next   = SPW'(STACK_DEPTH - 1);
                                stk_raddr = SAW'(STACK_DEPTH - 1);
                            end
                            else
                            begin
                                sp_next   = sp_reg - 1'b1;
                                stk_raddr = SAW'(sp_reg - 1'b1);
                            end
                            state_next = ST_RET;
                        end
                        else
                        begin
                            unk_next = 1'b1;
                        end
                    end
                    I_JP: pc_next = op_nnn;
                    I_CALL:
                    begin
                        stk_we = 1'b1;
                        if (sp_reg >= SPW'(STACK_DEPTH))
                        begin
                            serr_next = 1'b1;
                            stk_waddr = '0;
                            sp_next   = SPW'(1);
                        end
                        else
                        begin
                            sp_next = sp_reg + 1'b1;
                        end
                        pc_next = op_nnn;
                    end
                    I_SE, I_SER:
                    begin
                        if (alu_y.eq)
                        begin
                            pc_next = pc_reg + 12'd2;
                        end
                    end
                    I_SNE, I_SNER:
                    begin
                        if (!alu_y.eq)
                        begin
                            pc_next = pc_reg + 12'd2;
                        end
                    end
                    I_LD:
                    begin
                        reg_we    = 1'b1;
                        reg_wdata = op_nn;
                    end
                    I_ADD: reg_we = 1'b1;
                    I_ALU:
                    begin
                        unique case (op_n)
                            4'h0, 4'h1, 4'h2, 4'h3: reg_we = 1'b1;
                            4'h4, 4'h5, 4'h6, 4'h7, 4'hE:
                            begin
                                reg_we     = 1'b1;
                                flag_next  = alu_y.flag;
                                state_next = ST_FLAG;
                            end
                            default: unk_next = 1'b1;
                        endcase
                    end
                    I_LDI: idx_next = op_nnn;
                    I_JPV: pc_next = op_nnn + {4'd0, vy_in};
                    I_RND:
                    begin
                        reg_we    = 1'b1;
                        reg_wdata = rnd_reg & op_nn;
                    end
                    I_DRW:
                    begin
                        cnt_next   = '0;
                        hit_next   = 1'b0;
                        state_next = ST_DRAW_RD;
                    end
                    I_KEY:
                    begin
                        if (op_nn == K_SKP)
                        begin
                            if (key_down)
                            begin
                                pc_next = pc_reg + 12'd2;
                            end
                        end
                        else if (op_nn == K_SKNP)
                        begin
                            if (!key_down)
                            begin
                                pc_next = pc_reg + 12'd2;
                            end
                        end
                        else
                        begin
                            unk_next = 1'b1;
                        end
                    end
                    I_MISC:
                    begin
                        unique case (op_nn)
                            F_GET_DT:
                            begin
                                reg_we    = 1'b1;
                                reg_wdata = delay_reg;
                            end
                            F_WAITK:
                            begin
                                if (key_found)
                                begin
                                    reg_we    = 1'b1;
                                    reg_wdata = {4'd0, key_idx};
                                end
                                else
                                begin
                                    wait_next = 1'b1;
                                    pc_next   = pc_reg - 12'd2;
                                end
                            end
                            F_SET_DT: delay_next = vx_reg;
                            F_SET_ST: sound_next = vx_reg;
                            F_ADD_I:
                            begin
                                idx_next   = idx_sum[MEM_AW-1:0];
                                flag_next  = idx_sum[MEM_AW];
                                state_next = ST_FLAG;
                            end
                            F_FONT: idx_next = {2'd0, vx_reg, 2'd0} + {4'd0, vx_reg};
                            F_BCD:
                            begin
                                cnt_next   = '0;
                                state_next = ST_BCD;
                            end
                            F_STORE:
                            begin
                                cnt_next   = '0;
                                state_next = ST_STORE_RD;
                            end
                            F_LOAD:
                            begin
                                cnt_next   = '0;
                                state_next = ST_LOAD_RD;
                            end
                            default: unk_next = 1'b1;
                        endcase
                    end
                    default: unk_next = 1'b1;
                endcase
            end

            // VF written after the result
            ST_FLAG:
            begin
                reg_we     = 1'b1;
                reg_waddr  = FLAG_REG;
                reg_wdata  = {7'd0, flag_reg};
                state_next = ST_DONE;
            end

            ST_RET:
            begin
                pc_next    = stk_rdata;
                state_next = ST_DONE;
            end

            // sprite: read memory byte and display row
            ST_DRAW_RD:
            begin
                mem_raddr = mem_idx;
                if (draw_end)
                begin
                    flag_next  = hit_reg;
                    state_next = ST_FLAG;
                end
                else
                begin
                    state_next = ST_DRAW_WR;
                end
            end

            // xor the row back and note collisions
            ST_DRAW_WR:
            begin
                frm_we     = 1'b1;
                hit_next   = hit_reg | (|(frm_rdata & draw_mask));
                cnt_next   = cnt_reg + 12'd1;
                state_next = ST_DRAW_RD;
            end

            ST_CLS:
            begin
                frm_we    = 1'b1;
                frm_waddr = cnt_reg[4:0];
                frm_wdata = '0;
                cnt_next  = cnt_reg + 12'd1;
                if (cnt_reg[4:0] == 5'(ROWS - 1))
                begin
                    state_next = ST_DONE;
                end
            end

            ST_BCD:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 12'd1;
                if (cnt_reg[1:0] == 2'd2)
                begin
                    state_next = ST_DONE;
                end
            end

            // register block store
            ST_STORE_RD:
            begin
                reg_raddr  = cnt_reg[3:0];
                state_next = ST_STORE_WR;
            end

            ST_STORE_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = reg_rdata;
                cnt_next  = cnt_reg + 12'd1;
                state_next = (cnt_reg[3:0] == op_x) ? ST_DONE : ST_STORE_RD;
            end

            // register block load
            ST_LOAD_RD:
            begin
                mem_raddr  = mem_idx;
                state_next = ST_LOAD_WR;
            end

            ST_LOAD_WR:
            begin
                reg_we     = 1'b1;
                reg_waddr  = cnt_reg[3:0];
                reg_wdata  = mem_rdata;
                cnt_next   = cnt_reg + 12'd1;
                state_next = (cnt_reg[3:0] == op_x) ? ST_DONE : ST_LOAD_RD;
            end

            // hand the result to the output register
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_next      = {5'd0, unk_reg, serr_reg, wait_reg, row_reg,
                                     sound_reg, delay_reg, idx_reg, pc_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/c8ic_checker.sv
`include "chip8_instruction_core_assert.svh"

module c8ic_checker
    import c8ic_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic [1:0]       s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic s_fire;
    logic m_stall;

    assign s_fire  = s_tvalid & s_tready & (s_tuser != 2'd3 || s_tdata[0] == s_tdata[0]);
    assign m_stall = m_tvalid & ~m_tready;

    // one operation at a time: busy right after a word is taken
    `C8IC_ASSERT_NEXT(a_busy_after_accept, s_fire, !s_tready)

    // a stalled result keeps its contents
    `C8IC_ASSERT_NEXT(a_stall_holds, m_stall, m_tvalid && $stable(m_tdata))

    // at most one status flag per result
    `C8IC_ASSERT_NOW(a_one_status, m_tvalid, $countones(m_tdata[106:104]) <= 1)

    // fill bits stay clear
    `C8IC_ASSERT_NOW(a_fill_zero, m_tvalid, m_tdata[OUT_W-1:107] == '0)

endmodule

bind chip8_instruction_core c8ic_checker u_c8ic_checker (.*);
